// ----- src/u16u8_pkg.sv -----
// Shared types, constants and the UTF-8 encoder for the UTF-16 to UTF-8 transcoder.
package u16u8_pkg;

  // Default width of the running byte count
  localparam int LengthBitsDef = 16;

  // Capacity register value after reset
  localparam logic [15:0] CapacityReset = 16'd256;

  // Surrogate tags in the top six bits of a code unit
  localparam logic [5:0] SurHighTag = 6'b110110;
  localparam logic [5:0] SurLowTag  = 6'b110111;

  // Most data bytes one code unit can release: a lone high surrogate plus a BMP unit
  localparam int MaxDataBytes = 6;

  // One encoded code point: bytes[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      n;
  } utf8_enc_t;

  // Encode a code point of up to 21 bits into one to four UTF-8 bytes
  function automatic utf8_enc_t utf8_encode(input logic [20:0] cp);
    utf8_enc_t e;
    e.bytes = '0;
    if (cp < 21'h80) begin
      e.n        = 3'd1;
      e.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.n        = 3'd2;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n        = 3'd3;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.n        = 3'd4;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

endpackage

// ----- src/utf16_to_utf8_transcoder.sv -----
// Top level: UTF-16 to UTF-8 transcoder with capacity check and end-of-string status.
//
// Accepts one UTF-16 code unit per beat and releases its UTF-8 bytes, then a
// status beat (overflow flag and byte length) after the unit marked last_unit.
// Each unit is encoded in the cycle it is accepted and its beats (up to seven:
// six data bytes and the status) are parked in a run buffer, which feeds a
// one-beat output register. The result channel moves one beat per cycle while
// out_stall is low. A unit holds the input until its final beat leaves the run
// buffer (one to four beats for a typical unit, seven at most); units that release nothing do not hold it.
// A new unit is taken in the same cycle the run buffer hands its final beat to
// the output register, so a beat waiting at the output does not hold the input.
// The capacity register may be written at any time and applies to the next check.
module utf16_to_utf8_transcoder
  import u16u8_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_unit,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_is_data,
  output logic        out_last_in_run,
  output logic        out_overflow,
  output logic [15:0] out_byte_length
);

  // Width of sums and compares: room for the carry and for the 16-bit capacity
  localparam int CW = (LENGTH_BITS + 1 > 17) ? LENGTH_BITS + 1 : 17;

  // String state
  logic                   held_valid_r, held_valid_nxt;
  logic [9:0]             held_bits_r, held_bits_nxt;
  logic [LENGTH_BITS-1:0] byte_count_r, byte_count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [15:0]            cap_r;

  // Run buffer
  logic                           run_valid_r, run_valid_nxt;
  logic [2:0]                     run_idx_r, run_idx_nxt;
  logic [MaxDataBytes-1:0][7:0]   run_bytes_r;
  logic [2:0]                     run_ndata_r;
  logic                           run_stat_r;
  logic                           run_ovf_r;
  logic [15:0]                    run_len_r;

  // Output register
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_is_data_r;
  logic        out_last_r;
  logic        out_ovf_r;
  logic [15:0] out_len_r;

  // Encode datapath
  logic                   in_acc;
  logic                   is_high, is_low;
  logic [20:0]            cp1;
  utf8_enc_t              e1, e2;
  logic [CW-1:0]          sum1, sum2;
  logic                   try1, fit1, consumed, try2, fit2;
  logic [2:0]             n1, n2;
  logic [LENGTH_BITS-1:0] bc1;
  logic                   ovf1;
  logic [7:0][7:0]        cat;
  logic [2:0]             new_ndata;
  logic [2:0]             new_total;
  logic [CW-1:0]          len_ext;

  // Drain control
  logic       o_load;
  logic [2:0] run_total;
  logic       run_at_end;
  logic       run_cur_data;

  assign in_acc  = in_valid && !in_stall;
  assign is_high = (in_code_unit[15:10] == SurHighTag);
  assign is_low  = (in_code_unit[15:10] == SurLowTag);

  // First code point: the held high surrogate, paired or alone
  always_comb begin
    if (is_low) begin
      cp1 = 21'h10000 + {1'b0, held_bits_r, in_code_unit[9:0]};
    end else begin
      cp1 = {5'd0, SurHighTag, held_bits_r};
    end
  end

  assign e1   = utf8_encode(cp1);
  assign try1 = !ovf_r && held_valid_r;
  assign sum1 = CW'(byte_count_r) + CW'(e1.n);
  assign fit1 = !sum1[LENGTH_BITS] && (sum1 < CW'(cap_r));

  // Settle the first code point
  always_comb begin
    n1       = 3'd0;
    bc1      = byte_count_r;
    ovf1     = ovf_r;
    consumed = 1'b0;
    if (try1) begin
      consumed = is_low;
      if (fit1) begin
        n1  = e1.n;
        bc1 = sum1[LENGTH_BITS-1:0];
      end else begin
        ovf1 = 1'b1;
      end
    end
  end

  // Second code point: the current unit unless paired or held
  assign e2   = utf8_encode({5'd0, in_code_unit});
  assign try2 = !ovf1 && !consumed && !(is_high && !in_last_unit);
  assign sum2 = CW'(bc1) + CW'(e2.n);
  assign fit2 = !sum2[LENGTH_BITS] && (sum2 < CW'(cap_r));

  // Next string state
  always_comb begin
    n2             = 3'd0;
    byte_count_nxt = bc1;
    ovf_nxt        = ovf1;
    held_valid_nxt = held_valid_r;
    held_bits_nxt  = held_bits_r;
    if (!ovf_r) begin
      held_valid_nxt = 1'b0;
    end
    if (!ovf1 && !consumed && is_high && !in_last_unit) begin
      held_valid_nxt = 1'b1;
      held_bits_nxt  = in_code_unit[9:0];
    end
    if (try2) begin
      if (fit2) begin
        n2             = e2.n;
        byte_count_nxt = sum2[LENGTH_BITS-1:0];
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  // Lay the two encodings end to end
  always_comb begin
    unique case (n1)
      3'd3:    cat = {8'h00, e2.bytes, e1.bytes[2:0]};
      3'd4:    cat = {e2.bytes, e1.bytes};
      default: cat = {32'h0, e2.bytes};
    endcase
  end

  assign new_ndata = n1 + n2;
  assign new_total = new_ndata + {2'b00, in_last_unit};
  assign len_ext   = CW'(byte_count_nxt);

  // Drain the run buffer into the output register
  assign run_total    = run_ndata_r + {2'b00, run_stat_r};
  assign run_at_end   = (run_idx_r + 3'd1 == run_total);
  assign run_cur_data = (run_idx_r < run_ndata_r);
  assign o_load       = run_valid_r && (!out_valid_r || !out_stall);
  assign in_stall     = run_valid_r && !(o_load && run_at_end);

  always_comb begin
    run_valid_nxt = run_valid_r;
    run_idx_nxt   = run_idx_r;
    if (o_load) begin
      if (run_at_end) begin
        run_valid_nxt = 1'b0;
      end else begin
        run_idx_nxt = run_idx_r + 3'd1;
      end
    end
    if (in_acc && (new_total != 3'd0)) begin
      run_valid_nxt = 1'b1;
      run_idx_nxt   = 3'd0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (o_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
      byte_count_r <= '0;
      ovf_r        <= 1'b0;
      cap_r        <= CapacityReset;
      run_valid_r  <= 1'b0;
      run_idx_r    <= 3'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
      if (in_acc) begin
        if (in_last_unit) begin
          held_valid_r <= 1'b0;
          byte_count_r <= '0;
          ovf_r        <= 1'b0;
        end else begin
          held_valid_r <= held_valid_nxt;
          byte_count_r <= byte_count_nxt;
          ovf_r        <= ovf_nxt;
        end
      end
      run_valid_r <= run_valid_nxt;
      run_idx_r   <= run_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      held_bits_r <= held_bits_nxt;
      run_bytes_r <= cat[MaxDataBytes-1:0];
      run_ndata_r <= new_ndata;
      run_stat_r  <= in_last_unit;
      run_ovf_r   <= ovf_nxt;
      run_len_r   <= len_ext[15:0];
    end
    if (o_load) begin
      out_is_data_r <= run_cur_data;
      out_last_r    <= run_at_end;
      if (run_cur_data) begin
        out_byte_r <= run_bytes_r[run_idx_r];
        out_ovf_r  <= 1'b0;
        out_len_r  <= 16'd0;
      end else begin
        out_byte_r <= 8'h00;
        out_ovf_r  <= run_ovf_r;
        out_len_r  <= run_len_r;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_is_data     = out_is_data_r;
  assign out_last_in_run = out_last_r;
  assign out_overflow    = out_ovf_r;
  assign out_byte_length = out_len_r;

  // A surrogate is never held once the string has overflowed
  assert property (@(posedge clk) disable iff (!rst_n) held_valid_r |-> !ovf_r)
    else $error("high surrogate held after overflow");

  // A loaded run always has beats, and no more data bytes than fit
  assert property (@(posedge clk) disable iff (!rst_n)
    run_valid_r |-> (run_total != 3'd0) && (run_ndata_r <= 3'(MaxDataBytes)))
    else $error("run buffer holds an empty or oversized run");

  // A status beat always closes its run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_is_data_r) |-> out_last_r)
    else $error("status beat not marked last in run");

  // Closing a string returns the string state to rest
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_unit) |=> (byte_count_r == '0) && !held_valid_r && !ovf_r)
    else $error("string state not cleared after last unit");

  // The input is only taken once the run buffer can receive a new run
  assert property (@(posedge clk) disable iff (!rst_n)
    (run_valid_r && !o_load) |-> in_stall)
    else $error("input accepted while run buffer is blocked");

endmodule
